[hdl/fhp_pkg.sv]
// Shared constants, types and helpers for the fire heat propagation block.
package fhp_pkg;

    localparam int WIDTH  = 160;
    localparam int HEIGHT = 120;
    localparam int CELLS  = WIDTH * HEIGHT;

    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int HEAT_W = 8;
    localparam int SUM_W  = HEAT_W + 2;
    localparam int PX_W   = 8;
    localparam int PY_W   = 7;

    // floor(s / 3) == (s * 683) >> 11 for every s up to 4 * 255
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int PROD_W       = SUM_W + 10;

    localparam logic [3:0] COOL_BASE = 4'd3;

    // neighbor count codes
    localparam logic [1:0] NB_TWO   = 2'd0;
    localparam logic [1:0] NB_THREE = 2'd1;
    localparam logic [1:0] NB_FOUR  = 2'd2;

    localparam logic [COL_W-1:0] COL_LAST    = COL_W'(WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_BOTTOM  = ROW_W'(HEIGHT - 1);
    localparam logic [ROW_W-1:0] ROW_LASTUPD = ROW_W'(HEIGHT - 2);

    typedef struct packed {
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic              seed;
        logic              done;
        logic [HEAT_W-1:0] rnd;
        logic              a_zero;
        logic              b_zero;
        logic              has_left;
        logic              has_right;
        logic              has_below2;
    } scan_info_t;

    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic load_s3;
    } pipe_ctrl_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(WIDTH) + ADDR_W'(col));
    endfunction

endpackage

[hdl/fhp_heat_ram.sv]
// Heat store: one write port, two registered read ports.
module fhp_heat_ram
(
    input  logic                              clk,
    input  logic                              re,
    input  logic [fhp_pkg::ADDR_W-1:0]        raddr_a,
    input  logic [fhp_pkg::ADDR_W-1:0]        raddr_b,
    input  logic                              we,
    input  logic [fhp_pkg::ADDR_W-1:0]        waddr,
    input  logic [fhp_pkg::HEAT_W-1:0]        wdata,
    output logic [fhp_pkg::HEAT_W-1:0]        rdata_a,
    output logic [fhp_pkg::HEAT_W-1:0]        rdata_b
);

    logic [fhp_pkg::HEAT_W-1:0] mem [fhp_pkg::CELLS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[hdl/fhp_scan.sv]
// Raster position, frame phase and read address generation.
module fhp_scan
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [fhp_pkg::HEAT_W-1:0]      rnd,
    output fhp_pkg::scan_info_t             info,
    output logic [fhp_pkg::ADDR_W-1:0]      raddr_a,
    output logic [fhp_pkg::ADDR_W-1:0]      raddr_b
);

    logic [fhp_pkg::COL_W-1:0] col_reg, col_next;
    logic [fhp_pkg::ROW_W-1:0] row_reg, row_next;
    logic                      seed_reg, seed_next;
    logic                      first_reg, first_next;

    logic                      last_col;
    logic                      last_row;
    logic [fhp_pkg::ROW_W-1:0] row_p1;
    logic [fhp_pkg::ROW_W-1:0] row_p2;
    logic [fhp_pkg::COL_W-1:0] a_col;
    logic [fhp_pkg::ROW_W-1:0] a_row;

    assign last_col = (col_reg == fhp_pkg::COL_LAST);
    assign last_row = (row_reg == fhp_pkg::ROW_LASTUPD);
    assign row_p1   = fhp_pkg::ROW_W'(row_reg + fhp_pkg::ROW_W'(1));
    assign row_p2   = fhp_pkg::ROW_W'(row_reg + fhp_pkg::ROW_W'(2));

    // Port A fetches the below-right pixel; the last item of a row fetches
    // the below pixel of column 0 of the next updated row instead.
    always_comb
    begin
        a_col = '0;
        a_row = fhp_pkg::ROW_W'(1);
        if (!seed_reg)
        begin
            if (!last_col)
            begin
                a_col = fhp_pkg::COL_W'(col_reg + fhp_pkg::COL_W'(1));
                a_row = row_p1;
            end
            else if (!last_row)
            begin
                a_row = row_p2;
            end
        end
    end

    assign raddr_a = fhp_pkg::cell_addr(a_col, a_row);
    assign raddr_b = (!seed_reg && !last_row) ? fhp_pkg::cell_addr(col_reg, row_p2) : '0;

    always_comb
    begin
        info.x          = col_reg;
        info.y          = seed_reg ? fhp_pkg::ROW_BOTTOM : row_reg;
        info.seed       = seed_reg;
        info.done       = !seed_reg && last_col && last_row;
        info.rnd        = rnd;
        // before the first frame ends, of the rows read only the bottom row has been written
        info.a_zero     = first_reg && (a_row != fhp_pkg::ROW_BOTTOM);
        info.b_zero     = first_reg && (row_p2 != fhp_pkg::ROW_BOTTOM);
        info.has_left   = (col_reg != '0);
        info.has_right  = !last_col;
        info.has_below2 = !last_row;
    end

    always_comb
    begin
        col_next   = fhp_pkg::COL_W'(col_reg + fhp_pkg::COL_W'(1));
        row_next   = row_reg;
        seed_next  = seed_reg;
        first_next = first_reg;
        if (last_col)
        begin
            col_next = '0;
            if (seed_reg)
            begin
                row_next  = '0;
                seed_next = 1'b0;
            end
            else if (last_row)
            begin
                row_next   = '0;
                seed_next  = 1'b1;
                first_next = 1'b0;
            end
            else
            begin
                row_next = row_p1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            seed_reg  <= 1'b1;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            seed_reg  <= seed_next;
            first_reg <= first_next;
        end
    end

endmodule

[hdl/fhp_datapath.sv]
// Neighbor window, sum, average, cooling and result register.
module fhp_datapath
(
    input  logic                            clk,
    input  fhp_pkg::pipe_ctrl_t             ctrl,
    input  fhp_pkg::scan_info_t             info,
    input  logic [fhp_pkg::HEAT_W-1:0]      rdata_a,
    input  logic [fhp_pkg::HEAT_W-1:0]      rdata_b,
    output logic                            we,
    output logic [fhp_pkg::ADDR_W-1:0]      waddr,
    output logic [fhp_pkg::HEAT_W-1:0]      wdata,
    output logic [fhp_pkg::PX_W-1:0]        pixel_x,
    output logic [fhp_pkg::PY_W-1:0]        pixel_y,
    output logic [fhp_pkg::HEAT_W-1:0]      heat,
    output logic                            frame_done
);

    // stage 1: item info, read data and the two older window taps
    fhp_pkg::scan_info_t        s1_info_reg;
    logic [fhp_pkg::HEAT_W-1:0] center_reg;
    logic [fhp_pkg::HEAT_W-1:0] left_reg;
    logic [fhp_pkg::HEAT_W-1:0] right_val;
    logic [fhp_pkg::HEAT_W-1:0] below2_val;
    logic [fhp_pkg::SUM_W-1:0]  sum_next;
    logic [1:0]                 nb_next;

    // stage 2
    logic [fhp_pkg::COL_W-1:0]  s2_x_reg;
    logic [fhp_pkg::ROW_W-1:0]  s2_y_reg;
    logic                       s2_seed_reg;
    logic                       s2_done_reg;
    logic [fhp_pkg::HEAT_W-1:0] s2_rnd_reg;
    logic [fhp_pkg::SUM_W-1:0]  s2_sum_reg;
    logic [1:0]                 s2_nb_reg;
    logic [fhp_pkg::ADDR_W-1:0] s2_waddr_reg;

    logic [fhp_pkg::PROD_W-1:0] prod3;
    logic [fhp_pkg::HEAT_W-1:0] avg;
    logic [3:0]                 cool;
    logic [fhp_pkg::HEAT_W-1:0] heat_next;

    // stage 3: result
    logic [fhp_pkg::PX_W-1:0]   px_reg;
    logic [fhp_pkg::PY_W-1:0]   py_reg;
    logic [fhp_pkg::HEAT_W-1:0] heat_reg;
    logic                       done_reg;

    assign right_val  = s1_info_reg.a_zero ? '0 : rdata_a;
    assign below2_val = s1_info_reg.b_zero ? '0 : rdata_b;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
        begin
            s1_info_reg <= info;
            // shift the below row left by one column
            left_reg    <= center_reg;
            center_reg  <= right_val;
        end
    end

    always_comb
    begin
        sum_next = fhp_pkg::SUM_W'(center_reg);
        if (s1_info_reg.has_left)
        begin
            sum_next = fhp_pkg::SUM_W'(sum_next + fhp_pkg::SUM_W'(left_reg));
        end
        if (s1_info_reg.has_right)
        begin
            sum_next = fhp_pkg::SUM_W'(sum_next + fhp_pkg::SUM_W'(right_val));
        end
        if (s1_info_reg.has_below2)
        begin
            sum_next = fhp_pkg::SUM_W'(sum_next + fhp_pkg::SUM_W'(below2_val));
        end
        nb_next = 2'(2'(s1_info_reg.has_left) + 2'(s1_info_reg.has_right)
                     + 2'(s1_info_reg.has_below2) - 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s2)
        begin
            s2_x_reg     <= s1_info_reg.x;
            s2_y_reg     <= s1_info_reg.y;
            s2_seed_reg  <= s1_info_reg.seed;
            s2_done_reg  <= s1_info_reg.done;
            s2_rnd_reg   <= s1_info_reg.rnd;
            s2_sum_reg   <= sum_next;
            s2_nb_reg    <= nb_next;
            s2_waddr_reg <= fhp_pkg::cell_addr(s1_info_reg.x, s1_info_reg.y);
        end
    end

    assign prod3 = fhp_pkg::PROD_W'(fhp_pkg::PROD_W'(s2_sum_reg)
                                    * fhp_pkg::PROD_W'(fhp_pkg::RECIP3));

    always_comb
    begin
        case (s2_nb_reg)
            fhp_pkg::NB_TWO:   avg = fhp_pkg::HEAT_W'(s2_sum_reg >> 1);
            fhp_pkg::NB_THREE: avg = fhp_pkg::HEAT_W'(prod3 >> fhp_pkg::RECIP3_SHIFT);
            fhp_pkg::NB_FOUR:  avg = fhp_pkg::HEAT_W'(s2_sum_reg >> 2);
            default:           avg = '0;
        endcase
        cool = 4'(fhp_pkg::COOL_BASE + 4'(s2_rnd_reg[2:0]));
        if (s2_seed_reg)
        begin
            heat_next = s2_rnd_reg;
        end
        else if (avg > fhp_pkg::HEAT_W'(cool))
        begin
            heat_next = fhp_pkg::HEAT_W'(avg - fhp_pkg::HEAT_W'(cool));
        end
        else
        begin
            heat_next = '0;
        end
    end

    assign we    = ctrl.load_s3;
    assign waddr = s2_waddr_reg;
    assign wdata = heat_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s3)
        begin
            px_reg   <= fhp_pkg::PX_W'(s2_x_reg);
            py_reg   <= fhp_pkg::PY_W'(s2_y_reg);
            heat_reg <= heat_next;
            done_reg <= s2_done_reg;
        end
    end

    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign heat       = heat_reg;
    assign frame_done = done_reg;

endmodule

[hdl/fire_heat_propagation_core.sv]
// Top level of the fire heat propagation block: handshake and stage control.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | request   | in_valid / in_stall | random_byte
//  out     | result    | out_valid/out_stall | pixel_x, pixel_y, heat, frame_done
//
// One request per clock sustained while out_stall stays low; each result passes
// the heat store read, the neighbor sum, and the average and cooling stages
// before it is presented in the result register. The single write port and the
// two read ports of the heat store set the rate.
// Reset clears the raster position and stage valids at once; the heat store is
// not swept, because until the first frame ends every read outside the bottom
// row is forced to zero. in_stall rises only when all three stages hold results
// and out_stall is high; empty stages keep absorbing requests.
module fire_heat_propagation_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fhp_pkg::HEAT_W-1:0]      random_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fhp_pkg::PX_W-1:0]        pixel_x,
    output logic [fhp_pkg::PY_W-1:0]        pixel_y,
    output logic [fhp_pkg::HEAT_W-1:0]      heat,
    output logic                            frame_done
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;
    logic accept;

    fhp_pkg::pipe_ctrl_t        ctrl;
    fhp_pkg::scan_info_t        info;
    logic [fhp_pkg::ADDR_W-1:0] raddr_a;
    logic [fhp_pkg::ADDR_W-1:0] raddr_b;
    logic [fhp_pkg::HEAT_W-1:0] rdata_a;
    logic [fhp_pkg::HEAT_W-1:0] rdata_b;
    logic                       we;
    logic [fhp_pkg::ADDR_W-1:0] waddr;
    logic [fhp_pkg::HEAT_W-1:0] wdata;

    // a stage may load when it is empty or its content moves on
    assign s3_ready = !s3_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign accept   = in_valid && s1_ready;
    assign in_stall = !s1_ready;

    assign ctrl.load_s1 = accept;
    assign ctrl.load_s2 = s2_ready && s1_valid_reg;
    assign ctrl.load_s3 = s3_ready && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign out_valid = s3_valid_reg;

    // advance raster position and issue both neighbor reads on accept
    fhp_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rnd     (random_byte),
        .info    (info),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b)
    );

    fhp_heat_ram u_ram
    (
        .clk     (clk),
        .re      (accept),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // write back each pixel as it enters the result register
    fhp_datapath u_dp
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .info       (info),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .heat       (heat),
        .frame_done (frame_done)
    );

endmodule

[hdl/fhp_checker.sv]
// Port-level checks for the fire heat propagation block and their binding.
module fhp_port_checks
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [fhp_pkg::HEAT_W-1:0]      random_byte,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [fhp_pkg::PX_W-1:0]        pixel_x,
    input  logic [fhp_pkg::PY_W-1:0]        pixel_y,
    input  logic [fhp_pkg::HEAT_W-1:0]      heat,
    input  logic                            frame_done
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(heat) && $stable(pixel_x)
                                   && $stable(pixel_y) && $stable(frame_done))
        else $error("stalled result changed");

    // stall the input only when a valid result is stalled
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // frame end sits on the last updated pixel
    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> pixel_x == fhp_pkg::PX_W'(fhp_pkg::WIDTH - 1)
                                    && pixel_y == fhp_pkg::PY_W'(fhp_pkg::HEIGHT - 2))
        else $error("frame_done on wrong pixel");

    // the bottom row is only seeded, never flagged as frame end
    a_seed_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_y == fhp_pkg::PY_W'(fhp_pkg::HEIGHT - 1) |-> !frame_done)
        else $error("frame_done on seeded row");

endmodule

bind fire_heat_propagation_core fhp_port_checks u_fhp_port_checks (.*);

[bench/fhp_checker.sv]
// Checker for the fire heat propagation block: predicts each pixel and compares the results.
module fhp_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [fhp_pkg::HEAT_W-1:0] random_byte,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [fhp_pkg::PX_W-1:0]   pixel_x,
    input  logic [fhp_pkg::PY_W-1:0]   pixel_y,
    input  logic [fhp_pkg::HEAT_W-1:0] heat,
    input  logic                       frame_done,
    output int unsigned                fail_count,
    output int unsigned                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fhp_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PX_W-1:0]   x;
        logic [PY_W-1:0]   y;
        logic [HEAT_W-1:0] heat;
        logic              done;
    } pixel_t;

    // Private copy of the heat buffer and raster position.
    bit [HEAT_W-1:0] heat_map [CELLS];
    int unsigned     scan_col = 0;
    int unsigned     scan_row = 0;
    bit              seeding  = 1'b1;

    pixel_t expected_pixels [$];

    task automatic predict_pixel(input logic [HEAT_W-1:0] rnd);
        pixel_t      p;
        int unsigned x;
        int unsigned y;
        int unsigned sum;
        int unsigned cnt;
        int unsigned avg;
        int unsigned cool;
        int unsigned h;
        logic        done;
        x    = scan_col;
        done = 1'b0;
        if (seeding)
        begin
            y = HEIGHT - 1;
            h = rnd;
            heat_map[y * WIDTH + x] = h[HEAT_W-1:0];
            if (x == WIDTH - 1)
            begin
                scan_col = 0;
                scan_row = 0;
                seeding  = 1'b0;
            end
            else
            begin
                scan_col = x + 1;
            end
        end
        else
        begin
            y   = scan_row;
            sum = heat_map[(y + 1) * WIDTH + x];
            cnt = 1;
            // drop neighbors that fall outside the buffer
            if (x > 0)
            begin
                sum += heat_map[(y + 1) * WIDTH + x - 1];
                cnt++;
            end
            if (x + 1 < WIDTH)
            begin
                sum += heat_map[(y + 1) * WIDTH + x + 1];
                cnt++;
            end
            if (y + 2 < HEIGHT)
            begin
                sum += heat_map[(y + 2) * WIDTH + x];
                cnt++;
            end
            avg  = sum / cnt;
            cool = COOL_BASE + (rnd & 8'h07);
            h    = (avg > cool) ? avg - cool : 0;
            heat_map[y * WIDTH + x] = h[HEAT_W-1:0];
            if (x == WIDTH - 1)
            begin
                scan_col = 0;
                if (y + 1 >= HEIGHT - 1)
                begin
                    done     = 1'b1;
                    scan_row = 0;
                    seeding  = 1'b1;
                end
                else
                begin
                    scan_row = y + 1;
                end
            end
            else
            begin
                scan_col = x + 1;
            end
        end
        p.x    = x[PX_W-1:0];
        p.y    = y[PY_W-1:0];
        p.heat = h[HEAT_W-1:0];
        p.done = done;
        expected_pixels.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                heat_map[i] = '0;
            scan_col = 0;
            scan_row = 0;
            seeding  = 1'b1;
            expected_pixels.delete();
            pending_count = 0;
        end
        else
        begin
            // results never leave in the cycle their request enters, so check first
            if (out_valid && !out_stall)
            begin
                got = {pixel_x, pixel_y, heat, frame_done};
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected pixel x=%0d y=%0d heat=%0d done=%0b",
                                 $realtime, pixel_x, pixel_y, heat, frame_done);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: pixel mismatch: expected x=%0d y=%0d heat=%0d ",
                                      "done=%0b, got x=%0d y=%0d heat=%0d done=%0b"},
                                     $realtime, want.x, want.y, want.heat, want.done,
                                     got.x, got.y, got.heat, got.done);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_pixel(random_byte);
            pending_count = expected_pixels.size();
        end
    end

endmodule

[bench/fire_heat_propagation_core_tb.sv]
// Testbench top for the fire heat propagation block: stimulus, back-pressure and verdict.
module fire_heat_propagation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhp_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    // One frame is a seeding row plus HEIGHT-1 propagated rows.
    localparam int FRAME_ITEMS    = CELLS;
    localparam int DIRECTED_ITEMS = 25;
    // About 900 requests: the seeding row and the first propagated rows.
    localparam int TOTAL_ITEMS    = 900;
    localparam int QUIET_ITEMS    = 150;
    localparam int HOLD_OFF_AT    = 400;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_NS     = 1_000_000;

    typedef enum int unsigned {
        SEED_UNIFORM,
        SEED_HOT,
        SEED_ALTERNATE,
        SEED_SPARSE
    } seed_style_e;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [HEAT_W-1:0]   random_byte;
    logic                out_valid;
    logic                out_stall;
    logic [PX_W-1:0]     pixel_x;
    logic [PY_W-1:0]     pixel_y;
    logic [HEAT_W-1:0]   heat;
    logic                frame_done;

    int unsigned         fail_count;
    int unsigned         pending_count;

    // Handshake between the request driver and the result-side stall process.
    bit                  hold_off_req;
    bit                  quiet_tail;

    // Opening seeds: every bit both ways, isolated bits, and hot/cold neighbors
    // side by side so the averaging sees sharp edges.
    logic [HEAT_W-1:0] directed_bytes [DIRECTED_ITEMS] = '{
        8'h00, 8'hFF, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h80, 8'h7F,
        8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hF8, 8'h07,
        8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hC3, 8'h3C, 8'hFF,
        8'hF0
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    fire_heat_propagation_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .random_byte (random_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .heat        (heat),
        .frame_done  (frame_done)
    );

    fhp_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .random_byte   (random_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .heat          (heat),
        .frame_done    (frame_done),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Request driver: change inputs on the falling edge, hold each request
    // stable until the block takes it on a rising edge with in_stall low.
    initial
    begin
        int unsigned       sent;
        int unsigned       frame_pos;
        int unsigned       wait_cycles;
        seed_style_e       style;
        logic [HEAT_W-1:0] req_byte;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        random_byte = '0;
        style       = SEED_HOT;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (sent = 0; sent < TOTAL_ITEMS; sent++)
        begin
            frame_pos = sent % FRAME_ITEMS;
            // pick a fresh seeding style per frame; keep the first one hot so
            // the flames climb high enough to exercise deep rows
            if (frame_pos == 0 && sent != 0)
                style = seed_style_e'($urandom_range(SEED_UNIFORM, SEED_SPARSE));
            if (sent == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            if (sent == TOTAL_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;

            if (sent < DIRECTED_ITEMS)
            begin
                req_byte = directed_bytes[sent];
            end
            else if (frame_pos < WIDTH)
            begin
                // seeding row: the byte is the heat itself
                case (style)
                    SEED_HOT:       req_byte = 8'($urandom_range(192, 255));
                    SEED_ALTERNATE: req_byte = frame_pos[0] ? 8'h00 : 8'hFF;
                    SEED_SPARSE:    req_byte = ($urandom_range(0, 7) == 0) ?
                                               8'hFF : 8'($urandom_range(0, 15));
                    default:        req_byte = 8'($urandom);
                endcase
            end
            else
            begin
                // propagation: only the low three bits matter, as extra cooling
                req_byte = 8'($urandom);
            end

            // idle the request side in a short burst now and then
            if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end

            in_valid    <= 1'b1;
            random_byte <= req_byte;
            do
                @(posedge clk);
            while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;

        // drain: wait for every expected pixel, bounded, then let the outputs settle
        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("[fire_heat_propagation_core] OK");
        else
            $display("[fire_heat_propagation_core] ERROR");
        $finish;
    end

    // Result side: stall in random bursts, once hold off long enough to fill
    // all three stages and push back on requests, and stop stalling at the tail.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Hard limit on the whole run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[fire_heat_propagation_core] ERROR");
        $finish;
    end

endmodule

[fire_heat_propagation_core.f]
hdl/fhp_pkg.sv
hdl/fhp_heat_ram.sv
hdl/fhp_scan.sv
hdl/fhp_datapath.sv
hdl/fire_heat_propagation_core.sv
hdl/fhp_checker.sv
bench/fhp_checker.sv
bench/fire_heat_propagation_core_tb.sv
